// ===== rtl/core/sfmpc_pkg.sv =====
// sfmpc_pkg: shared types and constants for the sensor fault mask / power cycler.
// No dependencies; imported by sfmpc_chan and sensor_fault_mask_power_cycler_core.
`timescale 1ns / 1ps
`default_nettype none

package sfmpc_pkg;

    localparam int NUM_SENSORS = 6;
    localparam int COUNT_W     = 8;
    localparam int SW_POS_W    = 3;

    localparam logic [NUM_SENSORS-1:0] ALL_ENABLED   = 6'h3f;
    localparam logic [COUNT_W-1:0]     FAULT_SAT     = 8'd255;
    localparam logic [COUNT_W-1:0]     TIMEOUT_RESET = 8'd5;
    localparam logic [COUNT_W-1:0]     HOLDOFF_RESET = 8'd125;

    // config register indexes
    localparam logic [1:0] REG_COMMAND_ENABLE = 2'd0;
    localparam logic [1:0] REG_FAULT_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_CYCLE_HOLDOFF  = 2'd2;

    // sensor i drives power-switch request bit SWITCH_POS[i]
    localparam logic [SW_POS_W-1:0] SWITCH_POS [NUM_SENSORS] =
        '{3'd1, 3'd5, 3'd0, 3'd2, 3'd3, 3'd4};

    typedef struct packed {
        logic               enable;
        logic [COUNT_W-1:0] fault_timeout;
        logic [COUNT_W-1:0] cycle_holdoff;
    } chan_cfg_t;

    typedef struct packed {
        logic mask;
        logic request;
    } chan_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfmpc_chan.sv =====
// sfmpc_chan: one sensor channel, fault tick counter and power-cycle holdoff counter.
// Depends on sfmpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfmpc_chan
    import sfmpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire logic      fault,
    input  wire chan_cfg_t cfg,
    output chan_out_t      result
);

    logic [COUNT_W-1:0] fault_ticks_reg, fault_ticks_next;
    logic [COUNT_W-1:0] holdoff_reg, holdoff_next;
    logic [COUNT_W-1:0] ticks_inc;
    logic [COUNT_W-1:0] holdoff_mid;
    logic               request;

    always_comb
    begin
        ticks_inc   = (fault_ticks_reg == FAULT_SAT) ? fault_ticks_reg
                                                     : fault_ticks_reg + 1'b1;
        request     = 1'b0;
        holdoff_mid = holdoff_reg;
        if (fault)
        begin
            fault_ticks_next = ticks_inc;
            request          = (ticks_inc > cfg.fault_timeout) && (holdoff_reg == '0);
            if (request)
            begin
                holdoff_mid = cfg.cycle_holdoff;
            end
        end
        else if (!cfg.enable)
        begin
            fault_ticks_next = fault_ticks_reg;
        end
        else
        begin
            fault_ticks_next = '0;
        end
        // countdown also runs on the tick that loaded the counter
        holdoff_next = (holdoff_mid != '0) ? holdoff_mid - 1'b1 : holdoff_mid;
    end

    assign result.mask    = !fault && cfg.enable;
    assign result.request = request;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_ticks_reg <= '0;
            holdoff_reg     <= '0;
        end
        else if (step)
        begin
            fault_ticks_reg <= fault_ticks_next;
            holdoff_reg     <= holdoff_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sensor_fault_mask_power_cycler_core.sv =====
// Top level of the sensor fault mask / power cycler.
// Depends on sfmpc_pkg and sfmpc_chan.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   s_* carries one item per slow-frame tick: six fault flags, bit i = sensor i.
//   m_* returns one item per input: the enable mask and six power-cycle
//   request bits in power-switch order.
//   cfg_* writes command_enable (0), fault_timeout (1) or cycle_holdoff (2);
//   cfg_ready is always high, other indexes are dropped. Write only while idle.
// Timing:
//   An item is held in the input register, the six channels update
//   in parallel, and the result register shows it: m_tvalid rises once
//   the item moves on into the result register, which waits on m_tready.
//   One item per cycle sustained while m_tready stays high; the channel
//   counters are the only state carried between items.
// Reset:
//   All fault and holdoff counters clear, registers return to 63 / 5 / 125,
//   both pipeline stages empty.
// Stall:
//   While m_tready is low the result holds; one more item is accepted into
//   the input register, then s_tready drops until the result is taken.
module sensor_fault_mask_power_cycler_core
    import sfmpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [5:0] fault_bits, [7:6] zero

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [5:0] enable_mask, [11:6] cycle_request, [15:12] zero

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic [NUM_SENSORS-1:0] command_enable_reg;
    logic [COUNT_W-1:0]     fault_timeout_reg;
    logic [COUNT_W-1:0]     cycle_holdoff_reg;

    logic                   in_valid_reg;
    logic [NUM_SENSORS-1:0] in_fault_reg;
    logic                   out_valid_reg;
    logic [NUM_SENSORS-1:0] mask_reg, mask_next;
    logic [NUM_SENSORS-1:0] request_reg, request_next;

    logic                   advance;
    chan_out_t              chan_res [NUM_SENSORS];

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_enable_reg <= ALL_ENABLED;
            fault_timeout_reg  <= TIMEOUT_RESET;
            cycle_holdoff_reg  <= HOLDOFF_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COMMAND_ENABLE: command_enable_reg <= cfg_data[NUM_SENSORS-1:0];
                REG_FAULT_TIMEOUT:  fault_timeout_reg  <= cfg_data;
                REG_CYCLE_HOLDOFF:  cycle_holdoff_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_fault_reg <= s_tdata[NUM_SENSORS-1:0];
        end
    end

    for (genvar g = 0; g < NUM_SENSORS; g++)
    begin : g_chan
        chan_cfg_t ccfg;
        // enable, fault_timeout, cycle_holdoff from the top bit down
        assign ccfg = {command_enable_reg[g], fault_timeout_reg, cycle_holdoff_reg};

        sfmpc_chan u_chan (
            .clk    (clk),
            .rst_n  (rst_n),
            .step   (advance),
            .fault  (in_fault_reg[g]),
            .cfg    (ccfg),
            .result (chan_res[g])
        );
    end

    always_comb
    begin
        request_next = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            mask_next[i]                 = chan_res[i].mask;
            request_next[SWITCH_POS[i]]  = chan_res[i].request;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mask_reg    <= mask_next;
            request_reg <= request_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, request_reg, mask_reg};

    // a faulty sensor never shows as enabled
    a_mask_vs_fault: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (mask_reg & $past(in_fault_reg)) == '0)
        else $error("enable_mask set for a faulty sensor");

    // requests come only from faulty sensors; checked as never more requests than faults
    a_req_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> $countones(request_reg) <= $countones($past(in_fault_reg)))
        else $error("more requests than faults");

    // input side stalls only when both stages hold items
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("s_tready low with room in the pipeline");

endmodule

`default_nettype wire
